>>> sv/riccati_euler_solver_2x2_defines.svh
// Assertion macros for the checker file.
`ifndef RICCATI_EULER_SOLVER_2X2_DEFINES_SVH
`define RICCATI_EULER_SOLVER_2X2_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RICC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ricc check failed");

// Next-cycle implication, off during reset.
`define RICC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ricc check failed");

`endif

>>> sv/ricc_pkg.sv
package ricc_pkg;

    localparam int DataW       = 32;
    localparam int ProdW       = 64;
    localparam int CfgW        = 17;
    localparam int IterW       = 16;
    localparam int RW          = 31;
    localparam int CfgIdxW     = 2;
    localparam int FracBitsDef = 16;
    localparam int DivSteps    = ProdW;

    localparam logic [CfgW-1:0]  TimeStepRst  = CfgW'(655);
    localparam logic [CfgW-1:0]  TolRst       = CfgW'(66);
    localparam logic [IterW-1:0] IterLimitRst = IterW'(1000);

    localparam logic [CfgIdxW-1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ITER_LIMIT = 2'd2;

    // Multiplier operand sources; i and j come from the command index.
    typedef enum logic [2:0] {
        OPX_P_I0, OPX_P_I1, OPX_A_0I, OPX_A_1I, OPX_B0, OPX_B1, OPX_V_I, OPX_ACC
    } opx_t;

    typedef enum logic [2:0] {
        OPY_B0, OPY_B1, OPY_A_0J, OPY_A_1J, OPY_P_0J, OPY_P_1J, OPY_W_J, OPY_DT
    } opy_t;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_POST_NEW, ACC_POST_ADD, ACC_ADD_T,
        ACC_SUB_QUAD, ACC_ADD_Q, ACC_UPD, ACC_CHG
    } acc_op_t;

    typedef enum logic [1:0] {
        DST_NONE, DST_V, DST_W, DST_T
    } dst_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        opx_t       x_sel;
        opy_t       y_sel;
        acc_op_t    acc_op;
        dst_t       dst;
        logic       div_start;
        logic       commit;
        logic [1:0] idx;
    } ricc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic below_tol;
    } ricc_stat_t;

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
        logic signed [DataW-1:0] r;
        if (v[DataW] != v[DataW-1]) begin
            r = v[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        end else begin
            r = v[DataW-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/ricc_div.sv
module ricc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ricc_pkg::ProdW-1:0]   dividend,
    input  logic        [ricc_pkg::RW-1:0]      divisor,
    output logic                                busy,
    output logic signed [ricc_pkg::DataW-1:0]   quot
);

    localparam int CntW = $clog2(ricc_pkg::DivSteps + 1);
    localparam int PW   = ricc_pkg::ProdW;
    localparam int DW   = ricc_pkg::DataW;
    localparam int RW   = ricc_pkg::RW;

    logic                 busy_reg;
    logic [CntW-1:0]      cnt_reg;
    logic [PW-1:0]        quo_reg;
    logic [RW-1:0]        rem_reg;
    logic                 neg_reg;
    logic signed [DW-1:0] quot_reg;

    logic [RW:0]          rem_sh;
    logic                 fits;
    logic [RW:0]          rem_diff;

    assign rem_sh   = {rem_reg, quo_reg[PW-1]};
    assign fits     = rem_sh >= {1'b0, divisor};
    assign rem_diff = rem_sh - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntW'(ricc_pkg::DivSteps);
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CntW'(1);
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Restoring division on the magnitude, one quotient bit a cycle.
    always_ff @(posedge clk) begin
        if (start) begin
            neg_reg <= dividend[PW-1];
            quo_reg <= dividend[PW-1] ? PW'(-dividend) : PW'(dividend);
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= fits ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
                quo_reg <= {quo_reg[PW-2:0], fits};
            end else if (neg_reg) begin
                quot_reg <= (quo_reg > PW'(64'h8000_0000)) ? {1'b1, {(DW-1){1'b0}}}
                                                           : DW'(-quo_reg);
            end else begin
                quot_reg <= (quo_reg > PW'(64'h7FFF_FFFF)) ? {1'b0, {(DW-1){1'b1}}}
                                                           : quo_reg[DW-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

>>> sv/ricc_dp.sv
module ricc_dp #(
    parameter int FRAC_BITS = ricc_pkg::FracBitsDef
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ricc_pkg::ricc_cmd_t                cmd,
    output ricc_pkg::ricc_stat_t               stat,
    input  logic signed [ricc_pkg::DataW-1:0]  a_00,
    input  logic signed [ricc_pkg::DataW-1:0]  a_01,
    input  logic signed [ricc_pkg::DataW-1:0]  a_10,
    input  logic signed [ricc_pkg::DataW-1:0]  a_11,
    input  logic signed [ricc_pkg::DataW-1:0]  gain_0,
    input  logic signed [ricc_pkg::DataW-1:0]  gain_1,
    input  logic signed [ricc_pkg::DataW-1:0]  weight_00,
    input  logic signed [ricc_pkg::DataW-1:0]  weight_01,
    input  logic signed [ricc_pkg::DataW-1:0]  weight_10,
    input  logic signed [ricc_pkg::DataW-1:0]  weight_11,
    input  logic        [ricc_pkg::RW-1:0]     control_weight,
    input  logic        [ricc_pkg::CfgW-1:0]   time_step,
    input  logic        [ricc_pkg::CfgW-1:0]   tolerance,
    output logic signed [ricc_pkg::DataW-1:0]  sol_00,
    output logic signed [ricc_pkg::DataW-1:0]  sol_01,
    output logic signed [ricc_pkg::DataW-1:0]  sol_10,
    output logic signed [ricc_pkg::DataW-1:0]  sol_11
);

    localparam int DW = ricc_pkg::DataW;
    localparam int PW = ricc_pkg::ProdW;

    typedef logic signed [DW-1:0] word_t;

    word_t a00_reg, a01_reg, a10_reg, a11_reg;
    word_t b0_reg, b1_reg;
    word_t q00_reg, q01_reg, q10_reg, q11_reg;
    word_t p00_reg, p01_reg, p10_reg, p11_reg;
    word_t np00_reg, np01_reg, np10_reg, np11_reg;
    word_t v0_reg, v1_reg, w0_reg, w1_reg;
    word_t t_reg, acc_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [ricc_pkg::RW-1:0] r_reg;
    logic [DW-1:0]          maxch_reg;

    logic  ii, jj;
    word_t p_i0, p_i1, p_0j, p_1j, a_0i, a_1i, a_0j, a_1j, v_i, w_j;
    word_t p_ij, np_ij, q_ij;
    word_t op_x, op_y;
    logic signed [PW-1:0] shr;
    word_t m_val;
    word_t add_x, add_y;
    logic  add_sub;
    logic signed [DW:0] add_raw;
    word_t add_res;
    logic signed [DW:0] ch;
    logic [DW:0] ach;
    logic  div_busy;
    word_t quad;

    assign ii = cmd.idx[1];
    assign jj = cmd.idx[0];

    assign p_i0 = ii ? p10_reg : p00_reg;
    assign p_i1 = ii ? p11_reg : p01_reg;
    assign p_0j = jj ? p01_reg : p00_reg;
    assign p_1j = jj ? p11_reg : p10_reg;
    assign a_0i = ii ? a01_reg : a00_reg;
    assign a_1i = ii ? a11_reg : a10_reg;
    assign a_0j = jj ? a01_reg : a00_reg;
    assign a_1j = jj ? a11_reg : a10_reg;
    assign v_i  = ii ? v1_reg : v0_reg;
    assign w_j  = jj ? w1_reg : w0_reg;

    always_comb begin
        case (cmd.idx)
            2'd0:    begin p_ij = p00_reg; np_ij = np00_reg; q_ij = q00_reg; end
            2'd1:    begin p_ij = p01_reg; np_ij = np01_reg; q_ij = q01_reg; end
            2'd2:    begin p_ij = p10_reg; np_ij = np10_reg; q_ij = q10_reg; end
            default: begin p_ij = p11_reg; np_ij = np11_reg; q_ij = q11_reg; end
        endcase
    end

    always_comb begin
        case (cmd.x_sel)
            ricc_pkg::OPX_P_I0: op_x = p_i0;
            ricc_pkg::OPX_P_I1: op_x = p_i1;
            ricc_pkg::OPX_A_0I: op_x = a_0i;
            ricc_pkg::OPX_A_1I: op_x = a_1i;
            ricc_pkg::OPX_B0:   op_x = b0_reg;
            ricc_pkg::OPX_B1:   op_x = b1_reg;
            ricc_pkg::OPX_V_I:  op_x = v_i;
            default:            op_x = acc_reg;
        endcase
        case (cmd.y_sel)
            ricc_pkg::OPY_B0:   op_y = b0_reg;
            ricc_pkg::OPY_B1:   op_y = b1_reg;
            ricc_pkg::OPY_A_0J: op_y = a_0j;
            ricc_pkg::OPY_A_1J: op_y = a_1j;
            ricc_pkg::OPY_P_0J: op_y = p_0j;
            ricc_pkg::OPY_P_1J: op_y = p_1j;
            ricc_pkg::OPY_W_J:  op_y = w_j;
            default:            op_y = $signed({{(DW-ricc_pkg::CfgW){1'b0}}, time_step});
        endcase
    end

    // Scale the product back to the fixed-point grid (floor) and clamp.
    assign shr = prod_reg >>> FRAC_BITS;
    always_comb begin
        if (shr > PW'(64'sh7FFF_FFFF)) begin
            m_val = {1'b0, {(DW-1){1'b1}}};
        end else if (shr < -PW'(64'sh8000_0000)) begin
            m_val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            m_val = shr[DW-1:0];
        end
    end

    // One saturating adder serves every accumulator operation but ACC_POST_NEW and ACC_CHG.
    always_comb begin
        add_x   = acc_reg;
        add_y   = m_val;
        add_sub = 1'b0;
        case (cmd.acc_op)
            ricc_pkg::ACC_ADD_T:    add_y = t_reg;
            ricc_pkg::ACC_SUB_QUAD: begin add_y = quad; add_sub = 1'b1; end
            ricc_pkg::ACC_ADD_Q:    add_y = q_ij;
            ricc_pkg::ACC_UPD:      begin add_x = p_ij; add_y = acc_reg; end
            default: ;
        endcase
    end

    assign add_raw = add_sub ? ({add_x[DW-1], add_x} - {add_y[DW-1], add_y})
                             : ({add_x[DW-1], add_x} + {add_y[DW-1], add_y});
    assign add_res = ricc_pkg::sat33(add_raw);

    assign ch  = {np_ij[DW-1], np_ij} - {p_ij[DW-1], p_ij};
    assign ach = ch[DW] ? (DW+1)'(-ch) : (DW+1)'(ch);

    ricc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (r_reg),
        .busy     (div_busy),
        .quot     (quad)
    );

    always_ff @(posedge clk) begin
        if (cmd.mul_en) begin
            prod_reg <= PW'(op_x) * PW'(op_y);
        end

        case (cmd.acc_op)
            ricc_pkg::ACC_POST_NEW: acc_reg <= m_val;
            ricc_pkg::ACC_POST_ADD,
            ricc_pkg::ACC_ADD_T,
            ricc_pkg::ACC_SUB_QUAD,
            ricc_pkg::ACC_ADD_Q:    acc_reg <= add_res;
            ricc_pkg::ACC_UPD: begin
                case (cmd.idx)
                    2'd0:    np00_reg <= add_res;
                    2'd1:    np01_reg <= add_res;
                    2'd2:    np10_reg <= add_res;
                    default: np11_reg <= add_res;
                endcase
            end
            ricc_pkg::ACC_CHG: begin
                if (ach[DW-1:0] > maxch_reg) begin
                    maxch_reg <= ach[DW-1:0];
                end
            end
            default: ;
        endcase

        if (cmd.acc_op == ricc_pkg::ACC_POST_ADD) begin
            case (cmd.dst)
                ricc_pkg::DST_V: begin
                    if (ii) v1_reg <= add_res;
                    else    v0_reg <= add_res;
                end
                ricc_pkg::DST_W: begin
                    if (jj) w1_reg <= add_res;
                    else    w0_reg <= add_res;
                end
                ricc_pkg::DST_T: t_reg <= add_res;
                default: ;
            endcase
        end

        if (cmd.load) begin
            a00_reg   <= a_00;
            a01_reg   <= a_01;
            a10_reg   <= a_10;
            a11_reg   <= a_11;
            b0_reg    <= gain_0;
            b1_reg    <= gain_1;
            q00_reg   <= weight_00;
            q01_reg   <= weight_01;
            q10_reg   <= weight_10;
            q11_reg   <= weight_11;
            p00_reg   <= weight_00;
            p01_reg   <= weight_01;
            p10_reg   <= weight_10;
            p11_reg   <= weight_11;
            r_reg     <= (control_weight == '0) ? ricc_pkg::RW'(1) : control_weight;
            maxch_reg <= '0;
        end else if (cmd.commit) begin
            p00_reg   <= np00_reg;
            p01_reg   <= np01_reg;
            p10_reg   <= np10_reg;
            p11_reg   <= np11_reg;
            maxch_reg <= '0;
        end
    end

    assign stat.div_busy  = div_busy;
    assign stat.below_tol = maxch_reg < {{(DW-ricc_pkg::CfgW){1'b0}}, tolerance};

    assign sol_00 = p00_reg;
    assign sol_01 = p01_reg;
    assign sol_10 = p10_reg;
    assign sol_11 = p11_reg;

endmodule

>>> sv/ricc_ctrl.sv
module ricc_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ricc_pkg::IterW-1:0]     iteration_limit,
    input  ricc_pkg::ricc_stat_t           stat,
    output ricc_pkg::ricc_cmd_t            cmd,
    output logic                           busy,
    output logic                           done,
    output logic                           converged
);

    localparam int IW = ricc_pkg::IterW;

    localparam logic [3:0] VwLast   = 4'd5;
    localparam logic [3:0] ElemWait = 4'd8;
    localparam logic [3:0] ElemLast = 4'd14;

    typedef enum logic [2:0] {S_IDLE, S_VW, S_ELEM, S_COMMIT, S_DONE} state_t;

    state_t              state_reg, state_next;
    logic [3:0]          step_reg, step_next;
    logic [1:0]          idx_reg, idx_next;
    logic [IW-1:0]       iter_reg, iter_next;
    logic                conv_reg, conv_next;
    ricc_pkg::ricc_cmd_t cmd_reg, cmd_next;

    function automatic ricc_pkg::ricc_cmd_t decode(input state_t st, input logic [3:0] step,
                                                   input logic [1:0] idx);
        ricc_pkg::ricc_cmd_t c;
        c     = '0;
        c.idx = idx;
        case (st)
            S_VW: begin
                case (step)
                    4'd0: begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_P_I0;
                                c.y_sel = ricc_pkg::OPY_B0; end
                    4'd1: begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_P_I1;
                                c.y_sel = ricc_pkg::OPY_B1; c.acc_op = ricc_pkg::ACC_POST_NEW; end
                    4'd2: begin c.acc_op = ricc_pkg::ACC_POST_ADD; c.dst = ricc_pkg::DST_V; end
                    4'd3: begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_B0;
                                c.y_sel = ricc_pkg::OPY_P_0J; end
                    4'd4: begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_B1;
                                c.y_sel = ricc_pkg::OPY_P_1J; c.acc_op = ricc_pkg::ACC_POST_NEW; end
                    4'd5: begin c.acc_op = ricc_pkg::ACC_POST_ADD; c.dst = ricc_pkg::DST_W; end
                    default: ;
                endcase
            end
            S_ELEM: begin
                case (step)
                    4'd0:  begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_V_I;
                                 c.y_sel = ricc_pkg::OPY_W_J; end
                    4'd1:  begin c.div_start = 1'b1; c.mul_en = 1'b1;
                                 c.x_sel = ricc_pkg::OPX_P_I0; c.y_sel = ricc_pkg::OPY_A_0J; end
                    4'd2:  begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_P_I1;
                                 c.y_sel = ricc_pkg::OPY_A_1J;
                                 c.acc_op = ricc_pkg::ACC_POST_NEW; end
                    4'd3:  begin c.acc_op = ricc_pkg::ACC_POST_ADD; c.dst = ricc_pkg::DST_T; end
                    4'd4:  begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_A_0I;
                                 c.y_sel = ricc_pkg::OPY_P_0J; end
                    4'd5:  begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_A_1I;
                                 c.y_sel = ricc_pkg::OPY_P_1J;
                                 c.acc_op = ricc_pkg::ACC_POST_NEW; end
                    4'd6:  c.acc_op = ricc_pkg::ACC_POST_ADD;
                    4'd7:  c.acc_op = ricc_pkg::ACC_ADD_T;
                    4'd9:  c.acc_op = ricc_pkg::ACC_SUB_QUAD;
                    4'd10: c.acc_op = ricc_pkg::ACC_ADD_Q;
                    4'd11: begin c.mul_en = 1'b1; c.x_sel = ricc_pkg::OPX_ACC;
                                 c.y_sel = ricc_pkg::OPY_DT; end
                    4'd12: c.acc_op = ricc_pkg::ACC_POST_NEW;
                    4'd13: c.acc_op = ricc_pkg::ACC_UPD;
                    4'd14: c.acc_op = ricc_pkg::ACC_CHG;
                    default: ;
                endcase
            end
            S_COMMIT: c.commit = 1'b1;
            default: ;
        endcase
        return c;
    endfunction

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        conv_next  = conv_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    step_next  = '0;
                    idx_next   = '0;
                    iter_next  = '0;
                    conv_next  = 1'b0;
                    state_next = (iteration_limit == '0) ? S_DONE : S_VW;
                end
            end
            S_VW: begin
                if (step_reg == VwLast) begin
                    step_next = '0;
                    if (idx_reg == 2'd3) begin
                        state_next = S_ELEM;
                        idx_next   = '0;
                    end else begin
                        idx_next = 2'd3;
                    end
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_ELEM: begin
                if (step_reg == ElemWait) begin
                    if (!stat.div_busy) begin
                        step_next = step_reg + 4'd1;
                    end
                end else if (step_reg == ElemLast) begin
                    step_next = '0;
                    if (idx_reg == 2'd3) begin
                        state_next = S_COMMIT;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_COMMIT: begin
                iter_next = iter_reg + IW'(1);
                if (stat.below_tol) begin
                    conv_next  = 1'b1;
                    state_next = S_DONE;
                end else if (iter_reg + IW'(1) == iteration_limit) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_VW;
                    step_next  = '0;
                    idx_next   = '0;
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        cmd_next = decode(state_next, step_next, idx_next);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            iter_reg  <= '0;
            conv_reg  <= 1'b0;
            cmd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            iter_reg  <= iter_next;
            conv_reg  <= conv_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_comb begin
        cmd      = cmd_reg;
        cmd.load = (state_reg == S_IDLE) && start;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign converged = conv_reg;

endmodule

>>> sv/riccati_euler_solver_2x2.sv
// Channel     Handshake                  Payload
// ---------   ------------------------   -------------------------------------------
// command     start, busy                a_00..a_11, gain_0/1, weight_00..11,
//                                        control_weight
// result      done (one-cycle strobe)    sol_00..sol_11, converged
// config      cfg_valid, cfg_ready       cfg_index, cfg_data
//
// A transaction is taken when start is high and busy is low; busy rises the next cycle.
// One Euler iteration computes P*B and B'*P, then updates each element of P (a radix-2
// quadratic-term divide, only partly hidden by the products), and ends with a commit.
// busy stays high until the result, with done on the last busy cycle; a zero
// iteration limit goes straight to done.
// rst_n clears control and restores the configuration defaults; the result strobe
// cannot be stalled, so sol_* and converged must be sampled while done is high.
module riccati_euler_solver_2x2 #(
    parameter int FRAC_BITS = ricc_pkg::FracBitsDef
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command transaction
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ricc_pkg::DataW-1:0]   a_00,
    input  logic signed [ricc_pkg::DataW-1:0]   a_01,
    input  logic signed [ricc_pkg::DataW-1:0]   a_10,
    input  logic signed [ricc_pkg::DataW-1:0]   a_11,
    input  logic signed [ricc_pkg::DataW-1:0]   gain_0,
    input  logic signed [ricc_pkg::DataW-1:0]   gain_1,
    input  logic signed [ricc_pkg::DataW-1:0]   weight_00,
    input  logic signed [ricc_pkg::DataW-1:0]   weight_01,
    input  logic signed [ricc_pkg::DataW-1:0]   weight_10,
    input  logic signed [ricc_pkg::DataW-1:0]   weight_11,
    input  logic        [ricc_pkg::RW-1:0]      control_weight,
    // result transaction
    output logic                                done,
    output logic signed [ricc_pkg::DataW-1:0]   sol_00,
    output logic signed [ricc_pkg::DataW-1:0]   sol_01,
    output logic signed [ricc_pkg::DataW-1:0]   sol_10,
    output logic signed [ricc_pkg::DataW-1:0]   sol_11,
    output logic                                converged,
    // configuration write transaction
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [ricc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic        [ricc_pkg::CfgW-1:0]    cfg_data
);

    logic [ricc_pkg::CfgW-1:0]  time_step_reg;
    logic [ricc_pkg::CfgW-1:0]  tolerance_reg;
    logic [ricc_pkg::IterW-1:0] iter_limit_reg;

    ricc_pkg::ricc_cmd_t  cmd;
    ricc_pkg::ricc_stat_t stat;

    // Config writes are always taken; drop writes to unknown indexes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            time_step_reg  <= ricc_pkg::TimeStepRst;
            tolerance_reg  <= ricc_pkg::TolRst;
            iter_limit_reg <= ricc_pkg::IterLimitRst;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ricc_pkg::CFG_TIME_STEP:  time_step_reg  <= cfg_data;
                ricc_pkg::CFG_TOLERANCE:  tolerance_reg  <= cfg_data;
                ricc_pkg::CFG_ITER_LIMIT: iter_limit_reg <= cfg_data[ricc_pkg::IterW-1:0];
                default: ;
            endcase
        end
    end

    // Sequence the iteration: products, division, update, convergence check.
    ricc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .iteration_limit (iter_limit_reg),
        .stat            (stat),
        .cmd             (cmd),
        .busy            (busy),
        .done            (done),
        .converged       (converged)
    );

    // Hold operands and P; run the shared multiplier, adder and divider.
    ricc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .a_00           (a_00),
        .a_01           (a_01),
        .a_10           (a_10),
        .a_11           (a_11),
        .gain_0         (gain_0),
        .gain_1         (gain_1),
        .weight_00      (weight_00),
        .weight_01      (weight_01),
        .weight_10      (weight_10),
        .weight_11      (weight_11),
        .control_weight (control_weight),
        .time_step      (time_step_reg),
        .tolerance      (tolerance_reg),
        .sol_00         (sol_00),
        .sol_01         (sol_01),
        .sol_10         (sol_10),
        .sol_11         (sol_11)
    );

endmodule

>>> sv/ricc_checker.sv
`include "riccati_euler_solver_2x2_defines.svh"

module ricc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result only shows up while a solve is in flight.
    `RICC_ASSERT_NOW(a_done_busy, clk, rst_n, done, busy)
    // An accepted command makes the block busy.
    `RICC_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // The result strobe is never followed directly by another.
    `RICC_ASSERT_NEXT(a_done_once, clk, rst_n, done, !done)
    // After the result the block is free again.
    `RICC_ASSERT_NEXT(a_done_free, clk, rst_n, done, !busy)

endmodule

bind riccati_euler_solver_2x2 ricc_checker u_ricc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

>>> tb/sv/tb_top.sv
module tb_top;

    // One solve request: system matrix, input gain, state weight, control weight.
    typedef struct {
        longint     sys[2][2];
        longint     gain[2];
        longint     wt[2][2];
        logic [30:0] rw;
    } problem_t;

    // One solve outcome as the block reports it.
    typedef struct {
        logic signed [31:0] p00;
        logic signed [31:0] p01;
        logic signed [31:0] p10;
        logic signed [31:0] p11;
        logic               conv;
    } solution_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          start = 1'b0;
    logic                          busy;
    logic signed [31:0]            a_00 = '0, a_01 = '0, a_10 = '0, a_11 = '0;
    logic signed [31:0]            gain_0 = '0, gain_1 = '0;
    logic signed [31:0]            weight_00 = '0, weight_01 = '0;
    logic signed [31:0]            weight_10 = '0, weight_11 = '0;
    logic [ricc_pkg::RW-1:0]       control_weight = '0;
    logic                          done;
    logic signed [31:0]            sol_00, sol_01, sol_10, sol_11;
    logic                          converged;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ricc_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [ricc_pkg::CfgW-1:0]     cfg_data = '0;

    // Shadow copy of the configuration registers, tracked on every write.
    logic [ricc_pkg::CfgW-1:0]  step_reg  = ricc_pkg::TimeStepRst;
    logic [ricc_pkg::CfgW-1:0]  tol_reg   = ricc_pkg::TolRst;
    logic [ricc_pkg::IterW-1:0] limit_reg = ricc_pkg::IterLimitRst;

    solution_t pending_solutions[$];
    int        mismatches = 0;

    riccati_euler_solver_2x2 dut (
        .clk, .rst_n, .start, .busy,
        .a_00, .a_01, .a_10, .a_11, .gain_0, .gain_1,
        .weight_00, .weight_01, .weight_10, .weight_11, .control_weight,
        .done, .sol_00, .sol_01, .sol_10, .sol_11, .converged,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always #6 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #(12 * 6000000);
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor of the Euler Riccati iteration.
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Product with floor rounding of the dropped fraction, then saturation.
    function automatic longint fmul(longint x, longint y);
        return clamp32((x * y) >>> 16);
    endfunction

    function automatic solution_t solve_riccati(problem_t pr);
        longint    pm[2][2], nm[2][2], pv[2], wv[2];
        longint    r, dt, pa, atp, quad, der, ch;
        longint    worst;
        int        it;
        logic      conv;
        solution_t s;
        r = longint'(pr.rw);
        if (r == 0) r = 1;
        dt = longint'(step_reg);
        conv = 1'b0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                pm[i][j] = pr.wt[i][j];
        for (it = 0; it < int'(limit_reg) && !conv; it++)
        begin
            worst = 0;
            for (int i = 0; i < 2; i++)
            begin
                pv[i] = clamp32(fmul(pm[i][0], pr.gain[0]) + fmul(pm[i][1], pr.gain[1]));
                wv[i] = clamp32(fmul(pr.gain[0], pm[0][i]) + fmul(pr.gain[1], pm[1][i]));
            end
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                begin
                    pa   = clamp32(fmul(pm[i][0], pr.sys[0][j]) +
                                   fmul(pm[i][1], pr.sys[1][j]));
                    atp  = clamp32(fmul(pr.sys[0][i], pm[0][j]) +
                                   fmul(pr.sys[1][i], pm[1][j]));
                    quad = clamp32((pv[i] * wv[j]) / r);
                    der  = clamp32(clamp32(clamp32(pa + atp) - quad) + pr.wt[i][j]);
                    nm[i][j] = clamp32(pm[i][j] + fmul(der, dt));
                    ch = nm[i][j] - pm[i][j];
                    if (ch < 0) ch = -ch;
                    if (ch > worst) worst = ch;
                end
            pm = nm;
            if (worst < longint'(tol_reg)) conv = 1'b1;
        end
        s.p00 = pm[0][0][31:0];
        s.p01 = pm[0][1][31:0];
        s.p10 = pm[1][0][31:0];
        s.p11 = pm[1][1][31:0];
        s.conv = conv;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: the strobe cannot be held off, so sample every done.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && done)
        begin
            if (pending_solutions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding", $realtime);
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (sol_00 !== want.p00 || sol_01 !== want.p01 || sol_10 !== want.p10 ||
                    sol_11 !== want.p11 || converged !== want.conv)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: solution mismatch exp %0d %0d %0d %0d c%0b",
                                  " got %0d %0d %0d %0d c%0b"},
                                 $realtime, want.p00, want.p01, want.p10, want.p11,
                                 want.conv, sol_00, sol_01, sol_10, sol_11, converged);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Send one command transaction after a random gap; start stays high
    // across back-to-back requests so it is never lowered and raised in one step.
    task automatic send_problem(problem_t pr);
        int        gap;
        solution_t predicted;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        a_00 <= pr.sys[0][0][31:0];
        a_01 <= pr.sys[0][1][31:0];
        a_10 <= pr.sys[1][0][31:0];
        a_11 <= pr.sys[1][1][31:0];
        gain_0 <= pr.gain[0][31:0];
        gain_1 <= pr.gain[1][31:0];
        weight_00 <= pr.wt[0][0][31:0];
        weight_01 <= pr.wt[0][1][31:0];
        weight_10 <= pr.wt[1][0][31:0];
        weight_11 <= pr.wt[1][1][31:0];
        control_weight <= pr.rw;
        @(posedge clk);
        while (busy) @(posedge clk);
        // Accepted at this edge; predict with the configuration now in force.
        predicted = solve_riccati(pr);
        pending_solutions = {pending_solutions, predicted};
    endtask

    // Drop start and hold until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_solutions.size() != 0) @(posedge clk);
        // Let the block settle back to idle after its last strobe.
        repeat (8) @(posedge clk);
    endtask

    // Write one register; only called with the block idle.
    task automatic write_register(logic [ricc_pkg::CfgIdxW-1:0] idx,
                                  logic [ricc_pkg::CfgW-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ricc_pkg::CFG_TIME_STEP:  step_reg  = value;
            ricc_pkg::CFG_TOLERANCE:  tol_reg   = value;
            ricc_pkg::CFG_ITER_LIMIT: limit_reg = value[ricc_pkg::IterW-1:0];
            default: ;
        endcase
    endtask

    // Draw one signed Q16.16 value: full range, near unity, or an edge value.
    function automatic longint pick_fixed();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
            return longint'($signed($urandom()));
        if (mode < 8)
            return longint'($signed($urandom_range(0, 262143))) - 131072;
        case ($urandom_range(0, 5))
            0: return -64'sd2147483648;
            1: return 64'sd2147483647;
            2: return 0;
            3: return -1;
            4: return 65536;
            default: return -65536;
        endcase
    endfunction

    function automatic logic [30:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return 31'h7fffffff;
            1: return '0;
            2: return 31'($urandom());
            default: return 31'($urandom_range(1, 262144));
        endcase
    endfunction

    function automatic problem_t random_problem();
        problem_t pr;
        for (int i = 0; i < 2; i++)
        begin
            pr.gain[i] = pick_fixed();
            for (int j = 0; j < 2; j++)
            begin
                pr.sys[i][j] = pick_fixed();
                pr.wt[i][j]  = pick_fixed();
            end
        end
        pr.rw = pick_weight();
        return pr;
    endfunction

    // Every matrix and gain field set to one value; handy for the corner requests.
    function automatic problem_t uniform_problem(longint v, logic [30:0] rw);
        problem_t pr;
        for (int i = 0; i < 2; i++)
        begin
            pr.gain[i] = v;
            for (int j = 0; j < 2; j++)
            begin
                pr.sys[i][j] = v;
                pr.wt[i][j]  = v;
            end
        end
        pr.rw = rw;
        return pr;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset configuration: an all-zero problem converges on the first step.
    task automatic test_reset_defaults();
        problem_t pr;
        pr = uniform_problem(0, 31'd65536);
        send_problem(pr);
        pr.wt[0][0] = 64;
        pr.wt[1][1] = -64;
        send_problem(pr);
    endtask

    // Field extremes, zero control weight, saturation, the zero-limit case and config write edges.
    task automatic test_directed_edges();
        problem_t pr;
        write_register(ricc_pkg::CFG_ITER_LIMIT, 17'd2);
        send_problem(uniform_problem(64'sd2147483647, 31'h7fffffff));
        send_problem(uniform_problem(-64'sd2147483648, 31'h7fffffff));
        send_problem(uniform_problem(-64'sd2147483648, 31'd0));
        send_problem(uniform_problem(-1, 31'd1));
        send_problem(uniform_problem(65536, 31'd65536));
        pr = uniform_problem(0, 31'd0);
        pr.gain[0] = 64'sd2147483647;
        pr.gain[1] = -64'sd2147483648;
        pr.wt[0][1] = 64'sd2147483647;
        pr.wt[1][0] = -64'sd2147483648;
        send_problem(pr);
        // Zero limit: P comes back equal to Q without any step.
        write_register(ricc_pkg::CFG_ITER_LIMIT, 17'd0);
        send_problem(uniform_problem(12345, 31'd3));
        send_problem(random_problem());
        // Upper bit of the limit data is beyond the register and is dropped.
        write_register(ricc_pkg::CFG_ITER_LIMIT, 17'h10001);
        send_problem(uniform_problem(-131072, 31'd65536));
        // Unknown index leaves every register unchanged.
        write_register(2'd3, 17'h1ffff);
        send_problem(random_problem());
    endtask

    // Register extremes: zero and unit tolerance, zero, tiny, unit and oversize steps.
    task automatic test_register_extremes();
        write_register(ricc_pkg::CFG_TOLERANCE, 17'd0);
        write_register(ricc_pkg::CFG_ITER_LIMIT, 17'd3);
        send_problem(uniform_problem(0, 31'd65536));
        send_problem(random_problem());
        write_register(ricc_pkg::CFG_TIME_STEP, 17'd0);
        send_problem(random_problem());
        write_register(ricc_pkg::CFG_TIME_STEP, 17'd65536);
        write_register(ricc_pkg::CFG_TOLERANCE, 17'd65536);
        send_problem(random_problem());
        write_register(ricc_pkg::CFG_TIME_STEP, 17'h1ffff);
        send_problem(random_problem());
        send_problem(uniform_problem(64'sd2147483647, 31'd1));
        // Largest limit with a one-LSB step converges at once, so the run stays short.
        write_register(ricc_pkg::CFG_TIME_STEP, 17'd1);
        write_register(ricc_pkg::CFG_ITER_LIMIT, 17'hffff);
        repeat (4) send_problem(random_problem());
    endtask

    // Random problems over a sequence of random settings, short limits mostly.
    task automatic test_random_sweep();
        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 3))
                0: write_register(ricc_pkg::CFG_TIME_STEP, 17'($urandom_range(1, 64)));
                1: write_register(ricc_pkg::CFG_TIME_STEP, 17'($urandom_range(1, 65536)));
                2: write_register(ricc_pkg::CFG_TIME_STEP, 17'($urandom_range(0, 131071)));
                default: write_register(ricc_pkg::CFG_TIME_STEP, 17'd655);
            endcase
            case ($urandom_range(0, 3))
                0: write_register(ricc_pkg::CFG_TOLERANCE, 17'd0);
                1: write_register(ricc_pkg::CFG_TOLERANCE, 17'($urandom_range(0, 131071)));
                default: write_register(ricc_pkg::CFG_TOLERANCE,
                                        17'($urandom_range(1, 65536)));
            endcase
            if (ph == 5)
                write_register(ricc_pkg::CFG_ITER_LIMIT, 17'd12);
            else
                write_register(ricc_pkg::CFG_ITER_LIMIT, 17'($urandom_range(1, 3)));
            // A run of random problems, each sent after a random gap.
            for (int n = 0; n < ((ph == 5) ? 20 : 52); n++)
                send_problem(random_problem());
        end
        drain_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_edges();
        test_register_extremes();
        test_random_sweep();
        if (mismatches == 0 && pending_solutions.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
